### src/plane_ellipse_vertex_generator_assert.svh
// Assertion macros for the checker of the ellipse vertex generator.
`ifndef PLANE_ELLIPSE_VERTEX_GENERATOR_ASSERT_SVH
`define PLANE_ELLIPSE_VERTEX_GENERATOR_ASSERT_SVH

// Checked at every clock edge outside reset.
`define PEVG_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pevg check failed");

// Checked at every clock edge, reset included.
`define PEVG_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) else $error("pevg check failed");

`endif

### src/pevg_pkg.sv
`default_nettype none

package pevg_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CfgXDir    = 3'd0;
  localparam logic [2:0] CfgYDir    = 3'd1;
  localparam logic [2:0] CfgOriginX = 3'd2;
  localparam logic [2:0] CfgOriginY = 3'd3;
  localparam logic [2:0] CfgOriginZ = 3'd4;

  localparam logic [47:0] XDirReset = 48'h0000_0000_4000;
  localparam logic [47:0] YDirReset = 48'h0000_4000_0000;

  // One ellipse request as it sits in the queue.
  typedef struct packed {
    logic signed [31:0] center_u;
    logic signed [31:0] center_v;
    logic signed [31:0] major_u;
    logic signed [31:0] major_v;
    logic [15:0]        radius_ratio;
  } req_t;

  // Plane setup: directions are Q2.14, origin Q16.16.
  typedef struct packed {
    logic [2:0][15:0] xd;
    logic [2:0][15:0] yd;
    logic [2:0][31:0] org;
  } cfg_t;

  // Cosine and sine in signed Q2.30.
  typedef struct packed {
    logic signed [31:0] c;
    logic signed [31:0] s;
  } cs_t;

  // Cosine and sine of a phase given in turns (2^32 per turn), evaluated by
  // quadrant folding and Taylor series in Horner form. Used for constant tables.
  function automatic cs_t trig_cs(input logic [31:0] ph);
    logic [31:0]        q;
    logic [31:0]        rr;
    logic               rneg;
    logic [63:0]        mag;
    logic [63:0]        a;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic signed [31:0] c;
    logic signed [31:0] s;
    cs_t                res;
    q    = ((ph + 32'h2000_0000) >> 30) & 32'd3;
    rr   = ph - (q << 30);
    rneg = rr[31];
    mag  = rneg ? (64'h1_0000_0000 - {32'd0, rr}) : {32'd0, rr};
    a    = (mag * 64'd1686629713 + (64'd1 << 29)) >> 30;
    x2   = (a * a) >> 30;
    // Sine series.
    t = 64'd1 << 30;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd72;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd42;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd20;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd6;
    s = 32'((a * t) >> 30);
    if (rneg) begin
      s = -s;
    end
    // Cosine series.
    t = 64'd1 << 30;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd90;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd56;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd30;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd12;
    t = (64'd1 << 30) - ((x2 * t) >> 30) / 64'd2;
    c = 32'(t);
    case (q[1:0])
      2'd0: begin
        res.c = c;
        res.s = s;
      end
      2'd1: begin
        res.c = -s;
        res.s = c;
      end
      2'd2: begin
        res.c = -c;
        res.s = -s;
      end
      default: begin
        res.c = s;
        res.s = -c;
      end
    endcase
    return res;
  endfunction

  // Shift right by sh, rounding to nearest with ties away from zero.
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] p,
                                                input int unsigned sh);
    logic [63:0] m;
    m = p[63] ? 64'(-p) : 64'(p);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    return p[63] ? -$signed(m) : $signed(m);
  endfunction

  // Clamp to signed 32 bits.
  function automatic logic [31:0] sat32(input logic signed [41:0] v);
    logic [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -42'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/pevg_req_if.sv
`default_nettype none

// Request channel: one ellipse per beat.
interface pevg_req_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] center_u;
  logic signed [31:0] center_v;
  logic signed [31:0] major_u;
  logic signed [31:0] major_v;
  logic [15:0]        radius_ratio;

  modport source (
    output valid, center_u, center_v, major_u, major_v, radius_ratio,
    input  ready
  );
  modport sink (
    input  valid, center_u, center_v, major_u, major_v, radius_ratio,
    output ready
  );
endinterface

`default_nettype wire

### src/pevg_vtx_if.sv
`default_nettype none

// Vertex channel: one world-space vertex per beat.
interface pevg_vtx_if;
  logic               valid;
  logic               ready;
  logic [5:0]         vertex_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic               last_vertex;

  modport source (
    output valid, vertex_index, pos_x, pos_y, pos_z, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, vertex_index, pos_x, pos_y, pos_z, last_vertex,
    output ready
  );
endinterface

`default_nettype wire

### src/plane_ellipse_vertex_generator.sv
// Each request expands to VERTICES vertices, clamped to the range 4 to 64.
// Throughput: one vertex beat per cycle while vtx ready does not stall the output,
// set by the single vertex pipeline that all vertices pass through in turn.
// Up to two requests wait in the queue while a request is being expanded.
// Reset: plane x direction (1,0,0), y direction (0,1,0), origin zero, queue
// and pipeline empty.
`default_nettype none

module plane_ellipse_vertex_generator #(
  parameter int VERTICES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  pevg_req_if.sink         req_i,
  pevg_vtx_if.source       vtx_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [47:0] cfg_data_i
);

  // Configuration registers.
  logic [47:0] xdir_q;
  logic [47:0] ydir_q;
  logic [31:0] org_x_q, org_y_q, org_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xdir_q  <= pevg_pkg::XDirReset;
      ydir_q  <= pevg_pkg::YDirReset;
      org_x_q <= '0;
      org_y_q <= '0;
      org_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pevg_pkg::CfgXDir:    xdir_q  <= cfg_data_i;
        pevg_pkg::CfgYDir:    ydir_q  <= cfg_data_i;
        pevg_pkg::CfgOriginX: org_x_q <= cfg_data_i[31:0];
        pevg_pkg::CfgOriginY: org_y_q <= cfg_data_i[31:0];
        pevg_pkg::CfgOriginZ: org_z_q <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  pevg_pkg::cfg_t cfg;
  assign cfg.xd  = xdir_q;
  assign cfg.yd  = ydir_q;
  assign cfg.org = {org_z_q, org_y_q, org_x_q};

  // Front queue to vertex back end.
  pevg_pkg::req_t q_data;
  logic           q_valid;
  logic           q_pop;

  pevg_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_i),
    .q_data_o  (q_data),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  pevg_back #(
    .VERTICES (VERTICES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_data_i  (q_data),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .cfg_i     (cfg),
    .vtx       (vtx_o)
  );

endmodule

`default_nettype wire

### src/pevg_front.sv
`default_nettype none

// Request front end: takes request beats into a two-entry queue.
module pevg_front (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  pevg_req_if.sink        req,
  output pevg_pkg::req_t  q_data_o,
  output logic            q_valid_o,
  input  wire logic       q_pop_i
);

  pevg_pkg::req_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     cnt_q, cnt_d;
  logic           push;
  logic           pop;

  assign req.ready = (cnt_q != 2'd2);
  assign push      = req.valid && req.ready;
  assign pop       = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o  = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= '{center_u:     req.center_u,
                            center_v:     req.center_v,
                            major_u:      req.major_u,
                            major_v:      req.major_v,
                            radius_ratio: req.radius_ratio};
    end
  end

endmodule

`default_nettype wire

### src/pevg_back.sv
`default_nettype none

// Vertex back end: walks the vertices of one request; unless the output stalls,
// one vertex a cycle enters the scale, rotate and plane-mapping pipeline.
module pevg_back #(
  parameter int VERTICES = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire pevg_pkg::req_t q_data_i,
  input  wire logic           q_valid_i,
  output logic                q_pop_o,
  input  wire pevg_pkg::cfg_t cfg_i,
  pevg_vtx_if.source          vtx
);

  localparam int VCOUNT = (VERTICES < 4) ? 4 : ((VERTICES > 64) ? 64 : VERTICES);
  localparam int IdxW   = $clog2(VCOUNT);

  // Cosine and sine of each vertex angle.
  logic signed [31:0] cos_tab [VCOUNT];
  logic signed [31:0] sin_tab [VCOUNT];

  for (genvar g = 0; g < VCOUNT; g++) begin : g_tab
    localparam logic [31:0]    Ph = 32'((64'(g) << 32) / VCOUNT);
    localparam pevg_pkg::cs_t  Cs = pevg_pkg::trig_cs(Ph);
    assign cos_tab[g] = Cs.c;
    assign sin_tab[g] = Cs.s;
  end

  // Whole pipeline moves when the output register is free or being drained.
  logic adv;
  logic out_vld_q;
  assign adv = !out_vld_q || vtx.ready;

  // Sequencer over the vertices of the current request.
  logic            busy_q;
  logic [IdxW-1:0] cnt_q;
  pevg_pkg::req_t  cur_q;
  logic            last_iss;
  logic            take;

  assign last_iss = busy_q && (cnt_q == IdxW'(VCOUNT - 1));
  assign take     = adv && (!busy_q || last_iss);
  assign q_pop_o  = take && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (adv) begin
      if (take) begin
        busy_q <= q_valid_i;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_q <= q_data_i;
    end
  end

  // Valid bits of stages one to five.
  logic [5:1] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[4:1], busy_q};
      out_vld_q <= vld_q[5];
    end
  end

  // Stage one: table lookup.
  logic signed [31:0] c1_q, s1_q;
  logic [5:0]         idx1_q;
  logic               last1_q;
  pevg_pkg::req_t     r1_q;

  // Stage two: scaled sine.
  logic signed [31:0] c2_q;
  logic signed [29:0] rs2_q;
  logic [5:0]         idx2_q;
  logic               last2_q;
  logic signed [31:0] cu2_q, cv2_q, mu2_q, mv2_q;

  // Stage three: rotation products.
  logic signed [32:0] pcu3_q, pcv3_q;
  logic signed [36:0] prv3_q, pru3_q;
  logic [5:0]         idx3_q;
  logic               last3_q;
  logic signed [31:0] cu3_q, cv3_q;

  // Stage four: plane coordinates.
  logic signed [37:0] u4_q, v4_q;
  logic [5:0]         idx4_q;
  logic               last4_q;

  // Stage five: plane mapping products.
  logic signed [39:0] wx5_q [3];
  logic signed [39:0] wy5_q [3];
  logic [5:0]         idx5_q;
  logic               last5_q;

  logic signed [16:0] ratio17;
  logic signed [48:0] p_rs;
  logic signed [63:0] p_cu, p_cv;
  logic signed [61:0] p_rv, p_ru;
  logic signed [53:0] p_wx [3];
  logic signed [53:0] p_wy [3];
  logic signed [41:0] sum [3];
  logic [31:0]        pos [3];

  // Multipliers and rounding of each stage.
  always_comb begin
    ratio17 = {1'b0, r1_q.radius_ratio};
    p_rs    = s1_q * ratio17;
    p_cu    = c2_q * mu2_q;
    p_cv    = c2_q * mv2_q;
    p_rv    = rs2_q * mv2_q;
    p_ru    = rs2_q * mu2_q;
    for (int j = 0; j < 3; j++) begin
      p_wx[j] = u4_q * $signed(cfg_i.xd[j]);
      p_wy[j] = v4_q * $signed(cfg_i.yd[j]);
      sum[j]  = 42'(wx5_q[j]) + 42'(wy5_q[j]) + 42'($signed(cfg_i.org[j]));
      pos[j]  = pevg_pkg::sat32(sum[j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q    <= cos_tab[cnt_q];
      s1_q    <= sin_tab[cnt_q];
      idx1_q  <= 6'(cnt_q);
      last1_q <= last_iss;
      r1_q    <= cur_q;

      c2_q    <= c1_q;
      rs2_q   <= 30'(pevg_pkg::rnd_sh(64'(p_rs), 18));
      idx2_q  <= idx1_q;
      last2_q <= last1_q;
      cu2_q   <= r1_q.center_u;
      cv2_q   <= r1_q.center_v;
      mu2_q   <= r1_q.major_u;
      mv2_q   <= r1_q.major_v;

      pcu3_q  <= 33'(pevg_pkg::rnd_sh(p_cu, 30));
      pcv3_q  <= 33'(pevg_pkg::rnd_sh(p_cv, 30));
      prv3_q  <= 37'(pevg_pkg::rnd_sh(64'(p_rv), 24));
      pru3_q  <= 37'(pevg_pkg::rnd_sh(64'(p_ru), 24));
      idx3_q  <= idx2_q;
      last3_q <= last2_q;
      cu3_q   <= cu2_q;
      cv3_q   <= cv2_q;

      u4_q    <= 38'(cu3_q) + 38'(pcu3_q) - 38'(prv3_q);
      v4_q    <= 38'(cv3_q) + 38'(pcv3_q) + 38'(pru3_q);
      idx4_q  <= idx3_q;
      last4_q <= last3_q;

      for (int j = 0; j < 3; j++) begin
        wx5_q[j] <= 40'(pevg_pkg::rnd_sh(64'(p_wx[j]), 14));
        wy5_q[j] <= 40'(pevg_pkg::rnd_sh(64'(p_wy[j]), 14));
      end
      idx5_q  <= idx4_q;
      last5_q <= last4_q;

      vtx.vertex_index <= idx5_q;
      vtx.last_vertex  <= last5_q;
      vtx.pos_x        <= pos[0];
      vtx.pos_y        <= pos[1];
      vtx.pos_z        <= pos[2];
    end
  end

  assign vtx.valid = out_vld_q;

endmodule

`default_nettype wire

### src/pevg_chk.sv
`default_nettype none

`include "plane_ellipse_vertex_generator_assert.svh"

// Port-level checks of the ellipse vertex generator.
module pevg_chk #(
  parameter int VERTICES = 64
) (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       vtx_valid_i,
  input wire logic       vtx_ready_i,
  input wire logic       vtx_last_i,
  input wire logic [5:0] vtx_index_i
);

  localparam int VCOUNT = (VERTICES < 4) ? 4 : ((VERTICES > 64) ? 64 : VERTICES);

  // A stalled vertex beat stays put.
  `PEVG_ASSERT(a_vtx_hold, vtx_valid_i && !vtx_ready_i |=> vtx_valid_i && $stable(vtx_index_i))

  // The closing vertex of an ellipse carries the top index.
  `PEVG_ASSERT(a_last_idx, vtx_valid_i && vtx_last_i |-> vtx_index_i == 6'(VCOUNT - 1))

  // Back-to-back vertices of one ellipse count up by one.
  `PEVG_ASSERT(a_idx_step, vtx_valid_i && vtx_ready_i && !vtx_last_i |=> !vtx_valid_i || vtx_index_i == 6'($past(vtx_index_i) + 6'd1))

  // Nothing is offered while reset is held.
  `PEVG_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !vtx_valid_i)

endmodule

bind plane_ellipse_vertex_generator pevg_chk #(
  .VERTICES (VERTICES)
) u_pevg_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .vtx_valid_i (vtx_o.valid),
  .vtx_ready_i (vtx_o.ready),
  .vtx_last_i  (vtx_o.last_vertex),
  .vtx_index_i (vtx_o.vertex_index)
);

`default_nettype wire
